// ===== design/rcp_pkg.sv =====
// Shared types, constants and codes of the read coverage pileup block.
package rcp_pkg;

   localparam int unsigned SamplesDefault   = 4;
   localparam int unsigned PositionsDefault = 65536;
   localparam int unsigned MaxKmerDefault   = 255;

   localparam logic [11:0] RejectMask = 12'h704;
   localparam logic [31:0] CntMax     = 32'hFFFF_FFFF;
   localparam logic [16:0] OfsMax     = 17'h1_FFFF;
   localparam logic [7:0]  KmerReset  = 8'd36;

   typedef enum logic [2:0] {
      KIND_HEADER = 3'd0,
      KIND_BASE   = 3'd1,
      KIND_CIGAR  = 3'd2,
      KIND_END    = 3'd3,
      KIND_QCOV   = 3'd4,
      KIND_QGC    = 3'd5,
      KIND_QREADS = 3'd6,
      KIND_NONE   = 3'd7
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_REJECTED = 3'd1,
      ST_BAD_BASE = 3'd2,
      ST_BAD_OP   = 3'd3,
      ST_IGNORED  = 3'd4
   } status_type;

   localparam logic [3:0] BaseA = 4'd1;
   localparam logic [3:0] BaseC = 4'd2;
   localparam logic [3:0] BaseG = 4'd4;
   localparam logic [3:0] BaseT = 4'd8;
   localparam logic [3:0] BaseN = 4'd15;

   localparam logic [3:0] OpM = 4'd0;
   localparam logic [3:0] OpI = 4'd1;
   localparam logic [3:0] OpD = 4'd2;
   localparam logic [3:0] OpN = 4'd3;
   localparam logic [3:0] OpS = 4'd4;
   localparam logic [3:0] OpH = 4'd5;
   localparam logic [3:0] OpP = 4'd6;
   localparam logic [3:0] OpEq = 4'd7;
   localparam logic [3:0] OpX = 4'd8;

   localparam logic CsrMinQuality = 1'b0;
   localparam logic CsrKmerLength = 1'b1;

   // Datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_IDLE,
      OP_DECODE,
      OP_COV_READ,
      OP_COV_WRITE,
      OP_GC_READ,
      OP_GC_WRITE,
      OP_QUERY_READ,
      OP_QUERY_DONE,
      OP_CLEAR,
      OP_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic cov_more;   // another coverage increment is due
      logic gc_due;     // read end needs a histogram increment
      logic query_mem;  // query needs a memory read
      logic query_gc;   // that read is from the histogram
   } dp_stat_type;

   function automatic logic [16:0] sat_add17(input logic [16:0] a, input logic [16:0] b);
      logic [17:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[17] ? OfsMax : s[16:0];
   endfunction

   function automatic logic [31:0] sat_inc32(input logic [31:0] c);
      return (c == CntMax) ? c : c + 32'd1;
   endfunction

endpackage

// ===== design/rcp_ctrl.sv =====
// Controller state machine of the read coverage pileup block.
module rcp_ctrl
   import rcp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [8:0] {
      S_CLEAR  = 9'b000000001,
      S_IDLE   = 9'b000000010,
      S_DECIDE = 9'b000000100,
      S_COV_RD = 9'b000001000,
      S_COV_WR = 9'b000010000,
      S_GC_RD  = 9'b000100000,
      S_GC_WR  = 9'b001000000,
      S_QRY    = 9'b010000000,
      S_OUT    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // Hold a finished beat until taken: the next item is taken only once the output register is free or frees on accept
   logic rsp_valid_ff, rsp_valid_in;
   logic finish;

   assign rsp_tvalid = rsp_valid_ff;
   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_IDLE;
      finish   = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (stat.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.op   = OP_DECODE;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (stat.cov_more) state_in = S_COV_RD;
            else if (stat.gc_due) state_in = S_GC_RD;
            else if (stat.query_mem) state_in = S_QRY;
            else state_in = S_OUT;
         end
         S_COV_RD: begin
            cmd.op   = OP_COV_READ;
            state_in = S_COV_WR;
         end
         S_COV_WR: begin
            cmd.op   = OP_COV_WRITE;
            state_in = S_DECIDE;
         end
         S_GC_RD: begin
            cmd.op   = OP_GC_READ;
            state_in = S_GC_WR;
         end
         S_GC_WR: begin
            cmd.op   = OP_GC_WRITE;
            state_in = S_OUT;
         end
         S_QRY: begin
            cmd.op   = OP_QUERY_READ;
            state_in = S_OUT;
         end
         S_OUT: begin
            cmd.op   = stat.query_mem ? OP_QUERY_DONE : OP_FINISH;
            finish   = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (finish) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== design/rcp_dpath.sv =====
// Datapath of the read coverage pileup block: read state, counter memories, result register.
module rcp_dpath
   import rcp_pkg::*;
#(
   parameter int unsigned SAMPLES   = SamplesDefault,
   parameter int unsigned POSITIONS = PositionsDefault,
   parameter int unsigned MAX_KMER  = MaxKmerDefault
)(
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   input  logic [80:0] req_tdata,
   input  logic [2:0]  req_tuser,
   input  logic        csr_valid,
   input  logic        csr_index,
   input  logic [7:0]  csr_data,
   output logic [39:0] rsp_tdata
);

   localparam int unsigned SmpW   = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam int unsigned GcBins = MAX_KMER + 1;
   localparam int unsigned CovD   = SAMPLES * POSITIONS;
   localparam int unsigned GcD    = SAMPLES * GcBins;
   localparam int unsigned CovAW  = (CovD > 1) ? $clog2(CovD) : 1;
   localparam int unsigned GcAW   = (GcD > 1) ? $clog2(GcD) : 1;
   localparam int unsigned ClrW   = ((CovAW > GcAW) ? CovAW : GcAW) + 1;
   localparam logic [7:0]  KmerCap = (MAX_KMER > 255) ? 8'd255 : 8'(MAX_KMER);

   // Unpack request beat
   kind_type    kind;
   logic [1:0]  f_sample;
   logic [SmpW-1:0] f_smp;
   logic [15:0] f_position;
   logic [7:0]  f_quality;
   logic [9:0]  f_read_length;
   logic [11:0] f_flags;
   logic        f_has_cov;
   logic [3:0]  f_base;
   logic [3:0]  f_op;
   logic [15:0] f_clen;
   logic [7:0]  f_bin;

   assign kind          = kind_type'(req_tuser);
   assign f_sample      = req_tdata[1:0];
   assign f_smp         = SmpW'(f_sample);
   assign f_position    = req_tdata[17:2];
   assign f_quality     = req_tdata[25:18];
   assign f_read_length = req_tdata[35:26];
   assign f_flags       = req_tdata[47:36];
   assign f_has_cov     = req_tdata[48];
   assign f_base        = req_tdata[52:49];
   assign f_op          = req_tdata[56:53];
   assign f_clen        = req_tdata[72:57];
   assign f_bin         = req_tdata[80:73];

   // Config registers
   logic [7:0] min_quality_ff, kmer_length_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         min_quality_ff <= 8'd0;
         kmer_length_ff <= KmerReset;
      end else if (csr_valid) begin
         if (csr_index == CsrMinQuality) min_quality_ff <= csr_data;
         else                            kmer_length_ff <= csr_data;
      end
   end

   logic [7:0] eff_kmer;
   assign eff_kmer = (kmer_length_ff > KmerCap) ? KmerCap : kmer_length_ff;

   // Read state
   logic        active_ff, active_in;
   logic [SmpW-1:0] cur_smp_ff, cur_smp_in;
   logic        track_ff, track_in;
   logic [15:0] start_ff, start_in;
   logic [16:0] ref_ofs_ff, ref_ofs_in;
   logic [16:0] q_used_ff, q_used_in;
   logic [16:0] cov_left_ff, cov_left_in;
   logic [7:0]  base_idx_ff, base_idx_in;
   logic [7:0]  gc_cnt_ff, gc_cnt_in;
   logic [7:0]  n_cnt_ff, n_cnt_in;
   logic        gc_due_ff, gc_due_in;
   logic        qmem_ff, qmem_in;
   logic        qgc_ff, qgc_in;
   logic [2:0]  status_ff, status_in;
   logic [31:0] data_ff, data_in;
   logic [SmpW-1:0] q_smp_ff, q_smp_in;
   logic [15:0] q_pos_ff, q_pos_in;
   logic [7:0]  q_bin_ff, q_bin_in;
   logic [ClrW-1:0] clr_ff, clr_in;

   // Memories
   logic [31:0] cov_mem [CovD];
   logic [31:0] gc_mem  [GcD];
   logic [31:0] used_ff [SAMPLES];
   logic [31:0] used_in [SAMPLES];
   logic [31:0] rd_ff;

   logic [17:0] pos_sum;
   logic        pos_ok;
   logic [CovAW-1:0] cov_addr;
   logic [GcAW-1:0]  gc_addr;
   logic        smp_ok;
   logic [CovAW-1:0] q_cov_addr;
   logic [GcAW-1:0]  q_gc_addr;

   assign pos_sum  = {2'b0, start_ff} + {1'b0, ref_ofs_ff};
   assign pos_ok   = {14'd0, pos_sum} < 32'(POSITIONS);
   assign cov_addr = CovAW'(cur_smp_ff) * CovAW'(POSITIONS) + CovAW'(pos_sum);
   assign gc_addr  = GcAW'(cur_smp_ff) * GcAW'(GcBins) + GcAW'(gc_cnt_ff);
   assign smp_ok   = {30'd0, f_sample} < 32'(SAMPLES);
   assign q_cov_addr = CovAW'(q_smp_ff) * CovAW'(POSITIONS) + CovAW'(q_pos_ff);
   assign q_gc_addr  = GcAW'(q_smp_ff) * GcAW'(GcBins) + GcAW'(q_bin_ff);

   logic clr_last;
   assign clr_last = clr_ff == ClrW'((CovD > GcD) ? CovD - 1 : GcD - 1);

   // Memory ports: one read or one write per cycle, but the clear writes an entry of both memories
   always_ff @(posedge clock) begin
      if (cmd.op == OP_CLEAR) begin
         if (clr_ff < ClrW'(CovD)) cov_mem[clr_ff[CovAW-1:0]] <= 32'd0;
         if (clr_ff < ClrW'(GcD))  gc_mem[clr_ff[GcAW-1:0]]   <= 32'd0;
      end
      if (cmd.op == OP_COV_READ)   rd_ff <= cov_mem[cov_addr];
      if (cmd.op == OP_COV_WRITE && pos_ok) cov_mem[cov_addr] <= sat_inc32(rd_ff);
      if (cmd.op == OP_GC_READ)    rd_ff <= gc_mem[gc_addr];
      if (cmd.op == OP_GC_WRITE)   gc_mem[gc_addr] <= sat_inc32(rd_ff);
      if (cmd.op == OP_QUERY_READ) rd_ff <= qgc_ff ? gc_mem[q_gc_addr] : cov_mem[q_cov_addr];
   end

   // Next read state: clear sweep, beat decode, coverage walk, GC update end, query close
   always_comb begin
      active_in   = active_ff;
      cur_smp_in  = cur_smp_ff;
      track_in    = track_ff;
      start_in    = start_ff;
      ref_ofs_in  = ref_ofs_ff;
      q_used_in   = q_used_ff;
      cov_left_in = cov_left_ff;
      base_idx_in = base_idx_ff;
      gc_cnt_in   = gc_cnt_ff;
      n_cnt_in    = n_cnt_ff;
      gc_due_in   = gc_due_ff;
      qmem_in     = qmem_ff;
      qgc_in      = qgc_ff;
      status_in   = status_ff;
      data_in     = data_ff;
      q_smp_in    = q_smp_ff;
      q_pos_in    = q_pos_ff;
      q_bin_in    = q_bin_ff;
      clr_in      = clr_ff;
      used_in     = used_ff;
      unique case (cmd.op)
         OP_CLEAR: clr_in = clr_ff + ClrW'(1);
         OP_DECODE: begin
            gc_due_in   = 1'b0;
            qmem_in     = 1'b0;
            cov_left_in = '0;
            data_in     = '0;
            status_in   = ST_IGNORED;
            q_smp_in    = f_smp;
            q_pos_in    = f_position;
            q_bin_in    = f_bin;
            unique case (kind)
               KIND_HEADER: if (smp_ok) begin
                  active_in = 1'b0;
                  if (f_quality < min_quality_ff ||
                      {2'b0, f_read_length} < {4'b0, kmer_length_ff} ||
                      (f_flags & RejectMask) != '0) begin
                     status_in = ST_REJECTED;
                  end else begin
                     status_in        = ST_OK;
                     used_in[f_smp]   = sat_inc32(used_ff[f_smp]);
                     active_in   = 1'b1;
                     cur_smp_in  = f_smp;
                     track_in    = f_has_cov;
                     start_in    = f_position;
                     ref_ofs_in  = '0;
                     q_used_in   = '0;
                     base_idx_in = '0;
                     gc_cnt_in   = '0;
                     n_cnt_in    = '0;
                  end
               end
               KIND_BASE: if (active_ff && base_idx_ff < eff_kmer) begin
                  status_in = ST_OK;
                  priority if (f_base == BaseA || f_base == BaseT) begin
                     base_idx_in = base_idx_ff + 8'd1;
                  end else if (f_base == BaseC || f_base == BaseG) begin
                     gc_cnt_in   = gc_cnt_ff + 8'd1;
                     base_idx_in = base_idx_ff + 8'd1;
                  end else if (f_base == BaseN) begin
                     n_cnt_in    = n_cnt_ff + 8'd1;
                     base_idx_in = base_idx_ff + 8'd1;
                  end else begin
                     active_in = 1'b0;
                     status_in = ST_BAD_BASE;
                  end
               end
               KIND_CIGAR: if (active_ff) begin
                  status_in = ST_OK;
                  if (track_ff) begin
                     priority if (f_op == OpM || f_op == OpEq || f_op == OpX) begin
                        cov_left_in = {1'b0, f_clen};
                     end else if (f_op == OpD || f_op == OpN) begin
                        ref_ofs_in = sat_add17(ref_ofs_ff, {1'b0, f_clen});
                     end else if (f_op == OpI) begin
                        q_used_in = sat_add17(q_used_ff, {1'b0, f_clen});
                     end else if (f_op == OpS || f_op == OpH || f_op == OpP) begin
                        status_in = ST_OK;
                     end else begin
                        active_in = 1'b0;
                        status_in = ST_BAD_OP;
                     end
                  end
               end
               KIND_END: if (active_ff) begin
                  status_in = ST_OK;
                  active_in = 1'b0;
                  gc_due_in = (n_cnt_ff == 8'd0) && ({24'd0, gc_cnt_ff} < 32'(GcBins));
               end
               KIND_QCOV: if (smp_ok && {16'd0, f_position} < 32'(POSITIONS)) begin
                  qmem_in = 1'b1;
                  qgc_in  = 1'b0;
               end
               KIND_QGC: if (smp_ok && {24'd0, f_bin} < 32'(GcBins)) begin
                  qmem_in = 1'b1;
                  qgc_in  = 1'b1;
               end
               KIND_QREADS: if (smp_ok) begin
                  status_in = ST_OK;
                  data_in   = used_ff[f_smp];
               end
               default: status_in = ST_IGNORED;
            endcase
         end
         OP_COV_WRITE: begin
            cov_left_in = cov_left_ff - 17'd1;
            q_used_in   = sat_add17(q_used_ff, 17'd1);
            ref_ofs_in  = sat_add17(ref_ofs_ff, 17'd1);
         end
         OP_GC_WRITE: gc_due_in = 1'b0;
         OP_QUERY_DONE: begin
            status_in = ST_OK;
            data_in   = rd_ff;
         end
         default: ;
      endcase
   end

   // Register read state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         cur_smp_ff  <= '0;
         track_ff    <= 1'b0;
         start_ff    <= '0;
         ref_ofs_ff  <= '0;
         q_used_ff   <= '0;
         base_idx_ff <= '0;
         gc_cnt_ff   <= '0;
         n_cnt_ff    <= '0;
         cov_left_ff <= '0;
         gc_due_ff   <= 1'b0;
         qmem_ff     <= 1'b0;
         qgc_ff      <= 1'b0;
         status_ff   <= ST_IGNORED;
         data_ff     <= '0;
         q_smp_ff    <= '0;
         q_pos_ff    <= '0;
         q_bin_ff    <= '0;
         clr_ff      <= '0;
         for (int s = 0; s < SAMPLES; s++) used_ff[s] <= '0;
      end else begin
         active_ff   <= active_in;
         cur_smp_ff  <= cur_smp_in;
         track_ff    <= track_in;
         start_ff    <= start_in;
         ref_ofs_ff  <= ref_ofs_in;
         q_used_ff   <= q_used_in;
         base_idx_ff <= base_idx_in;
         gc_cnt_ff   <= gc_cnt_in;
         n_cnt_ff    <= n_cnt_in;
         cov_left_ff <= cov_left_in;
         gc_due_ff   <= gc_due_in;
         qmem_ff     <= qmem_in;
         qgc_ff      <= qgc_in;
         status_ff   <= status_in;
         data_ff     <= data_in;
         q_smp_ff    <= q_smp_in;
         q_pos_ff    <= q_pos_in;
         q_bin_ff    <= q_bin_in;
         clr_ff      <= clr_in;
         used_ff     <= used_in;
      end
   end

   assign stat.clear_done = clr_last;
   assign stat.cov_more   = (cov_left_ff != '0) && (q_used_ff < {9'd0, eff_kmer});
   assign stat.gc_due     = gc_due_ff;
   assign stat.query_mem  = qmem_ff;
   assign stat.query_gc   = qgc_ff;

   // Result beat: query data goes from the read register rd_ff into the result register
   logic [2:0]  out_status;
   logic [31:0] out_data;
   always_comb begin
      out_status = status_ff;
      out_data   = data_ff;
   end

   logic [39:0] rsp_ff;
   always_ff @(posedge clock) begin
      if (cmd.op == OP_QUERY_DONE)  rsp_ff <= {5'd0, rd_ff, ST_OK};
      else if (cmd.op == OP_FINISH) rsp_ff <= {5'd0, out_data, out_status};
   end
   assign rsp_tdata = rsp_ff;

endmodule

// ===== design/read_coverage_pileup_top.sv =====
// Top level of the read coverage pileup block.
// Each request beat yields one response beat, held in an output register until taken; the
// block works on one item at a time. A header, base, read end without histogram update,
// used-read query, non-match CIGAR element or ignored item passes through decode, decide
// and output; a coverage or histogram query adds a memory read; a read end that bumps a
// GC bin adds a histogram read and write; a match element adds a read, write and decide
// on the coverage memory per counted position, at most kmer_length positions. The next
// beat is taken in the cycle the response leaves, so a stalled response holds the input.
// After reset the block sweeps its memories clear, one entry of each a cycle up to the
// larger depth, before it takes the first request.
module read_coverage_pileup_top
   import rcp_pkg::*;
#(
   parameter int unsigned SAMPLES   = SamplesDefault,
   parameter int unsigned POSITIONS = PositionsDefault,
   parameter int unsigned MAX_KMER  = MaxKmerDefault
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // sample[1:0] position[17:2] quality[25:18] read_length[35:26] flags[47:36]
   // has_coverage[48] base_code[52:49] cigar_op[56:53] cigar_length[72:57] gc_bin[80:73]
   input  logic [87:0] req_tdata,
   input  logic [2:0]  req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // status[2:0] read_data[34:3]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign csr_ready = 1'b1;

   rcp_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready,
      .rsp_tvalid, .rsp_tready, .stat, .cmd
   );

   rcp_dpath #(.SAMPLES(SAMPLES), .POSITIONS(POSITIONS), .MAX_KMER(MAX_KMER)) u_dpath (
      .clock, .reset, .cmd, .stat, .req_tdata(req_tdata[80:0]), .req_tuser,
      .csr_valid, .csr_index, .csr_data, .rsp_tdata
   );

   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while busy");
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped");
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("response changed while stalled");

endmodule
